/* design/dpbp_pkg.sv */
// Package for the depth pixel back-projection block.
// Holds the configuration register indexes and reset constants; no dependencies.
package dpbp_pkg;

  // Configuration port index width and register indexes.
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL_X  = 2'd0,
    REG_FOCAL_Y  = 2'd1,
    REG_CENTER_X = 2'd2,
    REG_CENTER_Y = 2'd3
  } cfg_reg_e;

  // Reset values: focal lengths in whole pixels, centers in whole pixels.
  localparam int unsigned FOCAL_RESET_PX = 600;
  localparam int unsigned CENTER_X_RESET = 320;
  localparam int unsigned CENTER_Y_RESET = 240;

endpackage

/* design/dpbp_if.sv */
// Valid/ready channel interfaces for pixel input and point output.
// Stand-alone; widths come from the interface parameters.
interface dpbp_in_if #(
  parameter int unsigned CW = 12,
  parameter int unsigned VW = 24
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] pixel_col;
  logic [CW-1:0] pixel_row;
  logic [VW-1:0] ray_depth;

  modport source (output valid, pixel_col, pixel_row, ray_depth, input ready);
  modport sink (input valid, pixel_col, pixel_row, ray_depth, output ready);
endinterface

interface dpbp_out_if #(
  parameter int unsigned VW = 24
);
  logic               valid;
  logic               ready;
  logic signed [VW:0] pos_x;
  logic signed [VW:0] pos_y;
  logic [VW-1:0]      pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

/* design/depth_pixel_backprojection.sv */
// Top level of the pinhole depth back-projection block.
// Depends on dpbp_pkg, dpbp_if, dpbp_div and dpbp_sqrt.
//
// Converts one pixel (column, row) and a depth along its viewing ray into a
// camera-frame point (x, y upward, z forward) in Q.FRAC_BITS fixed point, x
// and y signed, z unsigned. The block accepts one transaction every clock cycle
// while the output is not stalled and delivers results in order. From input
// acceptance to output valid the pipeline holds, with default parameters, one
// input stage, a 39-stage bit-serial divider for the lateral ratios, a squaring
// stage and a sum stage, a 32-stage square root, a 43-stage divider for z, one
// product stage and the output register. The whole pipeline stalls together
// while a finished result waits on the output, so input ready follows output
// ready combinationally when the output register is full. Configuration writes
// take effect at once and must be made only while the pipeline is empty.
module depth_pixel_backprojection
  import dpbp_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [16+FRAC_BITS-1:0]       cfg_data_i,
  dpbp_in_if.sink                       in_i,
  dpbp_out_if.source                    out_o
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned FB  = FRAC_BITS;
  localparam int unsigned VW  = 16 + FB;
  localparam int unsigned RB  = 31 - CW;
  localparam int unsigned QB  = CW + RB;
  localparam int unsigned DNW = CW + RB + FB;
  localparam int unsigned KW  = 2 * QB + 2;
  localparam int unsigned HW  = KW / 2;
  localparam int unsigned ZNW = VW + RB;

  // Configuration registers.
  logic [VW-1:0] fx_q, fy_q;
  logic [CW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fx_q <= VW'(FOCAL_RESET_PX) << FB;
      fy_q <= VW'(FOCAL_RESET_PX) << FB;
      cx_q <= CW'(CENTER_X_RESET);
      cy_q <= CW'(CENTER_Y_RESET);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FOCAL_X:  fx_q <= cfg_data_i;
        REG_FOCAL_Y:  fy_q <= cfg_data_i;
        REG_CENTER_X: cx_q <= cfg_data_i[CW-1:0];
        REG_CENTER_Y: cy_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Focal lengths below one pixel are used as exactly one.
  logic [VW-1:0] fx_c, fy_c;
  assign fx_c = (fx_q < (VW'(1) << FB)) ? (VW'(1) << FB) : fx_q;
  assign fy_c = (fy_q < (VW'(1) << FB)) ? (VW'(1) << FB) : fy_q;

  // Global advance: every stage moves when the output register can take data.
  logic out_vld_q;
  logic adv;
  assign adv      = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // Stage 1: offsets from the optical center as sign and magnitude.
  logic          s1_vld_q;
  logic [CW-1:0] s1_au_q, s1_av_q;
  logic          s1_uneg_q, s1_vneg_q;
  logic [VW-1:0] s1_depth_q;
  logic          u_neg, v_neg;

  assign u_neg = in_i.pixel_col < cx_q;
  assign v_neg = in_i.pixel_row < cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_au_q    <= u_neg ? (cx_q - in_i.pixel_col) : (in_i.pixel_col - cx_q);
      s1_av_q    <= v_neg ? (cy_q - in_i.pixel_row) : (in_i.pixel_row - cy_q);
      s1_uneg_q  <= u_neg;
      s1_vneg_q  <= v_neg;
      s1_depth_q <= in_i.ray_depth;
    end
  end

  // Lateral ratios qu = |u| / fx and qv = |v| / fy with RB fraction bits.
  logic           du_vld, dv_vld;
  logic [DNW-1:0] du_quot, dv_quot;
  logic [VW:0]    du_side;
  logic           dv_side;

  dpbp_div #(.NW(DNW), .DW(VW), .SW(VW + 1)) u_div_u (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s1_vld_q),
    .dividend_i ({s1_au_q, {(RB + FB){1'b0}}}),
    .divisor_i  (fx_c),
    .side_i     ({s1_depth_q, s1_uneg_q}),
    .valid_o    (du_vld),
    .quot_o     (du_quot),
    .side_o     (du_side)
  );

  dpbp_div #(.NW(DNW), .DW(VW), .SW(1)) u_div_v (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (s1_vld_q),
    .dividend_i ({s1_av_q, {(RB + FB){1'b0}}}),
    .divisor_i  (fy_c),
    .side_i     (s1_vneg_q),
    .valid_o    (dv_vld),
    .quot_o     (dv_quot),
    .side_o     (dv_side)
  );

  // Squaring stage.
  logic            m1_vld_q;
  logic [QB-1:0]   m1_qu_q, m1_qv_q;
  logic [2*QB-1:0] m1_squ_q, m1_sqv_q;
  logic [VW-1:0]   m1_depth_q;
  logic            m1_uneg_q, m1_vneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= du_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_qu_q    <= du_quot[QB-1:0];
      m1_qv_q    <= dv_quot[QB-1:0];
      m1_squ_q   <= du_quot[QB-1:0] * du_quot[QB-1:0];
      m1_sqv_q   <= dv_quot[QB-1:0] * dv_quot[QB-1:0];
      m1_depth_q <= du_side[VW:1];
      m1_uneg_q  <= du_side[0];
      m1_vneg_q  <= dv_side;
    end
  end

  // Sum of squares plus one (in Q.2RB).
  logic          m2_vld_q;
  logic [KW-1:0] m2_ksq_q;
  logic [QB-1:0] m2_qu_q, m2_qv_q;
  logic [VW-1:0] m2_depth_q;
  logic          m2_uneg_q, m2_vneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (adv) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_ksq_q   <= (KW'(1) << (2 * RB)) + {2'b00, m1_squ_q} + {2'b00, m1_sqv_q};
      m2_qu_q    <= m1_qu_q;
      m2_qv_q    <= m1_qv_q;
      m2_depth_q <= m1_depth_q;
      m2_uneg_q  <= m1_uneg_q;
      m2_vneg_q  <= m1_vneg_q;
    end
  end

  // Ray length factor K = sqrt(1 + qu^2 + qv^2) in Q.RB.
  logic                 sq_vld;
  logic [HW-1:0]        sq_root;
  logic [2*QB+VW+1:0]   sq_side;

  dpbp_sqrt #(.KW(KW), .SW(2 * QB + VW + 2)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m2_vld_q),
    .rad_i   (m2_ksq_q),
    .side_i  ({m2_qu_q, m2_qv_q, m2_depth_q, m2_uneg_q, m2_vneg_q}),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Forward distance z = depth / K.
  logic             dz_vld;
  logic [ZNW-1:0]   dz_quot;
  logic [2*QB+1:0]  dz_side;

  dpbp_div #(.NW(ZNW), .DW(HW), .SW(2 * QB + 2)) u_div_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (sq_vld),
    .dividend_i ({sq_side[VW+1:2], {RB{1'b0}}}),
    .divisor_i  (sq_root),
    .side_i     ({sq_side[2*QB+VW+1:VW+2], sq_side[1:0]}),
    .valid_o    (dz_vld),
    .quot_o     (dz_quot),
    .side_o     (dz_side)
  );

  // Lateral products z * qu and z * qv.
  logic             p_vld_q;
  logic [VW+QB-1:0] p_x_q, p_y_q;
  logic [VW-1:0]    p_z_q;
  logic             p_uneg_q, p_vneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= dz_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_x_q    <= dz_quot[VW-1:0] * dz_side[2*QB+1:QB+2];
      p_y_q    <= dz_quot[VW-1:0] * dz_side[QB+1:2];
      p_z_q    <= dz_quot[VW-1:0];
      p_uneg_q <= dz_side[1];
      p_vneg_q <= dz_side[0];
    end
  end

  // Output register: drop the ratio fraction bits and apply the signs.
  logic [VW-1:0] mx, my;
  assign mx = p_x_q[RB+VW-1:RB];
  assign my = p_y_q[RB+VW-1:RB];

  logic [VW:0]   pos_x_q, pos_y_q;
  logic [VW-1:0] pos_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_q <= p_uneg_q ? (~{1'b0, mx} + 1'b1) : {1'b0, mx};
      pos_y_q <= p_vneg_q ? {1'b0, my} : (~{1'b0, my} + 1'b1);
      pos_z_q <= p_z_q;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.pos_x = pos_x_q;
  assign out_o.pos_y = pos_y_q;
  assign out_o.pos_z = pos_z_q;

  // The two ratio dividers run in lockstep.
  a_ratio_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    du_vld == dv_vld)
    else $error("ratio dividers out of step");

  // K is never below one, so z never exceeds the depth.
  a_root_at_least_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_vld |-> (sq_root >= (HW'(1) << RB)))
    else $error("ray length factor below one");

  // A zero forward distance gives zero lateral coordinates.
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && pos_z_q == '0) |-> (pos_x_q == '0 && pos_y_q == '0))
    else $error("nonzero lateral output with zero z");

endmodule

/* design/dpbp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Used by the back-projection top level; no package dependencies.
module dpbp_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [DW-1:0] dvs_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic          vld_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] dvs_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign num_in  = dividend_i;
      assign dvs_in  = divisor_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign num_in  = num_q[k-1];
      assign dvs_in  = dvs_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign take  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    // The used dividend bits shift out as quotient bits shift in.
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        num_q[k]  <= {num_in[NW-2:0], take};
        dvs_q[k]  <= dvs_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quot_o  = num_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

/* design/dpbp_sqrt.sv */
// Pipelined integer square root, one root bit per stage (two radicand bits).
// Used by the back-projection top level; no package dependencies.
module dpbp_sqrt #(
  parameter int unsigned KW = 16,
  parameter int unsigned SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [KW-1:0]   rad_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [KW/2-1:0] root_o,
  output logic [SW-1:0]   side_o
);

  localparam int unsigned HW = KW / 2;

  logic [HW+1:0] rem_q  [HW];
  logic [HW-1:0] root_q [HW];
  logic [KW-1:0] rad_q  [HW];
  logic [SW-1:0] side_q [HW];
  logic          vld_q  [HW];

  for (genvar k = 0; k < HW; k++) begin : g_stage
    logic [HW+1:0] rem_in;
    logic [HW-1:0] root_in;
    logic [KW-1:0] rad_in;
    logic [SW-1:0] side_in;
    logic          vld_in;
    logic [HW+3:0] shifted;
    logic [HW+3:0] trial;
    logic [HW+3:0] diff;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down two radicand bits and test the next root bit.
    assign shifted = {rem_in, rad_in[KW-1:KW-2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign diff    = shifted - trial;
    assign take    = (shifted >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[HW+1:0] : shifted[HW+1:0];
        root_q[k] <= {root_in[HW-2:0], take};
        rad_q[k]  <= {rad_in[KW-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[HW-1];
  assign root_o  = root_q[HW-1];
  assign side_o  = side_q[HW-1];

endmodule
